// ===== design/skf_pkg.sv =====
// Shared types and constants for the scalar Kalman filter.
package skf_pkg;

	localparam int WORD_W = 32;

	// Reset values of the configuration registers
	localparam logic [WORD_W-1:0] PROC_NOISE_RESET  = 32'd655;
	localparam logic [WORD_W-1:0] MEAS_NOISE_RESET  = 32'd65536;
	localparam logic [WORD_W-1:0] START_EST_RESET   = 32'd0;
	localparam logic [WORD_W-1:0] START_ERR_RESET   = 32'd65536;

	typedef enum logic [1:0] {
		OP_PREDICT = 2'd0,
		OP_UPDATE  = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CFG_PROC_NOISE = 2'd0,
		CFG_MEAS_NOISE = 2'd1,
		CFG_START_EST  = 2'd2,
		CFG_START_ERR  = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_PREP,
		S_MUL,
		S_APPLY,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;      // input transfer: latch operands, run predict and restart
		logic div_step;  // one restoring-divide step
		logic prep;      // fix gain, load multiplier operands
		logic mul_step;  // one shift-add step of both products
		logic apply;     // write new estimate and variance
		logic out_load;  // copy state into the output register
	} cmd_t;

	typedef struct packed {
		logic is_update;
	} sts_t;

endpackage

// ===== design/scalar_kalman_filter.sv =====
// Top level of the scalar Kalman filter: controller plus datapath.
// One-dimensional Kalman filter, constant-state model, Q16.16 by default (FRAC_BITS
// fraction bits). Each input transfer returns exactly one result: estimate, error
// variance and last gain after the step. Predict, restart and the unused code go
// straight to FINISH and the output register. An update first runs a restoring
// divider for the gain, one quotient bit per cycle (FRAC_BITS+1 steps), then two
// shift-add multipliers side by side, one multiplier bit per cycle (FRAC_BITS+1
// steps), then APPLY and FINISH. One item is in work at a time; the output register
// lets the next item be taken while a result waits. Configuration writes are taken
// every cycle and should only be issued while the block is idle.
module scalar_kalman_filter #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           operation,
	input  logic signed [31:0]   measurement,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   estimate,
	output logic [31:0]          error_variance,
	output logic [FRAC_BITS:0]   gain
);
	import skf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	skf_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	skf_dpath #(
		.FRAC_BITS(FRAC_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.operation     (operation),
		.measurement   (measurement),
		.cmd           (cmd),
		.sts           (sts),
		.estimate      (estimate),
		.error_variance(error_variance),
		.gain          (gain)
	);

endmodule

// ===== design/skf_ctrl.sv =====
// Controller state machine: sequences the divide and multiply steps and the output register.
module skf_ctrl #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  skf_pkg::sts_t sts,
	output skf_pkg::cmd_t cmd
);
	import skf_pkg::*;

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic last;
	logic out_valid_q;

	assign last = (cnt_q == CNT_W'(FRAC_BITS));
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == S_DIV || state_q == S_MUL) begin
			cnt_q <= last ? '0 : cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.is_update ? S_DIV : S_FINISH;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (last) state_d = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (last) state_d = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				// wait for the output slot to free up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DIV && state_q != S_MUL) |-> cnt_q == '0)
		else $error("step counter not cleared outside divide/multiply");

	a_update_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && sts.is_update) |=> state_q == S_DIV)
		else $error("update transfer did not start the divider");

	a_prep_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PREP |-> $past(state_q) == S_DIV)
		else $error("gain prepared without a divide");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

endmodule

// ===== design/skf_dpath.sv =====
// Datapath: configuration, filter state, serial divider, serial multipliers, output register.
module skf_dpath #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [31:0]               cfg_data,
	input  logic [1:0]                operation,
	input  logic signed [31:0]        measurement,
	input  skf_pkg::cmd_t             cmd,
	output skf_pkg::sts_t             sts,
	output logic signed [31:0]        estimate,
	output logic [31:0]               error_variance,
	output logic [FRAC_BITS:0]        gain
);
	import skf_pkg::*;

	localparam int GW = FRAC_BITS + 1;
	localparam int XW = FRAC_BITS + 34;  // gain times residual, signed
	localparam int VW = FRAC_BITS + 33;  // (one - gain) times variance
	localparam logic [GW-1:0] ONE = GW'(1) << FRAC_BITS;

	logic [31:0] pn_q, mn_q, se_q, ser_q;
	logic signed [31:0] est_q;
	logic [31:0] var_q;
	logic [GW-1:0] gain_q;

	logic [32:0] den_q;
	logic [33:0] rem_q;
	logic [GW-1:0] quo_q;
	logic signed [32:0] diff_q;
	logic [GW-1:0] mk_q, mo_q;
	logic signed [XW-1:0] accx_q;
	logic [VW-1:0] accv_q;

	logic signed [31:0] est_out_q;
	logic [31:0] var_out_q;
	logic [GW-1:0] gain_out_q;

	logic [32:0] psum;
	logic ge;
	logic [33:0] rem_sub;
	logic [GW-1:0] k_fix;
	logic signed [33:0] xs;
	logic signed [34:0] nx;
	logic signed [31:0] nx_clamped;

	assign sts.is_update = (operation == OP_UPDATE);

	assign psum    = {1'b0, var_q} + {1'b0, pn_q};
	assign ge      = (rem_q >= {1'b0, den_q});
	assign rem_sub = ge ? rem_q - {1'b0, den_q} : rem_q;
	assign k_fix   = (den_q == '0) ? '0 : quo_q;
	assign xs      = accx_q[XW-1:FRAC_BITS];
	assign nx      = {{3{est_q[31]}}, est_q} + {xs[33], xs};

	always_comb begin
		// saturate only if the top bits disagree
		if (nx[34:31] == 4'b0000 || nx[34:31] == 4'b1111) begin
			nx_clamped = nx[31:0];
		end else if (nx[34]) begin
			nx_clamped = {1'b1, 31'd0};
		end else begin
			nx_clamped = {1'b0, {31{1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pn_q  <= PROC_NOISE_RESET;
			mn_q  <= MEAS_NOISE_RESET;
			se_q  <= START_EST_RESET;
			ser_q <= START_ERR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PROC_NOISE: pn_q  <= cfg_data;
				CFG_MEAS_NOISE: mn_q  <= cfg_data;
				CFG_START_EST:  se_q  <= cfg_data;
				CFG_START_ERR:  ser_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q  <= START_EST_RESET;
			var_q  <= START_ERR_RESET;
			gain_q <= '0;
		end else if (cmd.load) begin
			case (operation)
				OP_PREDICT: var_q <= psum[32] ? '1 : psum[31:0];
				OP_RESTART: begin
					est_q  <= se_q;
					var_q  <= ser_q;
					gain_q <= '0;
				end
				default: ;  // update runs later; unused code holds state
			endcase
		end else if (cmd.prep) begin
			gain_q <= k_fix;
		end else if (cmd.apply) begin
			est_q <= nx_clamped;
			var_q <= accv_q[FRAC_BITS+31:FRAC_BITS];
		end
	end

	// working registers of the divider and multipliers, and the output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			den_q  <= {1'b0, var_q} + {1'b0, mn_q};
			rem_q  <= {2'b00, var_q};
			diff_q <= {measurement[31], measurement} - {est_q[31], est_q};
		end
		if (cmd.div_step) begin
			rem_q <= {rem_sub[32:0], 1'b0};
			quo_q <= {quo_q[GW-2:0], ge};
		end
		if (cmd.prep) begin
			mk_q   <= k_fix;
			mo_q   <= ONE - k_fix;
			accx_q <= '0;
			accv_q <= '0;
		end
		if (cmd.mul_step) begin
			accx_q <= (accx_q <<< 1)
				+ (mk_q[GW-1] ? {{(XW-33){diff_q[32]}}, diff_q} : XW'(0));
			accv_q <= {accv_q[VW-2:0], 1'b0}
				+ (mo_q[GW-1] ? {{(VW-32){1'b0}}, var_q} : VW'(0));
			mk_q <= {mk_q[GW-2:0], 1'b0};
			mo_q <= {mo_q[GW-2:0], 1'b0};
		end
		if (cmd.out_load) begin
			est_out_q  <= est_q;
			var_out_q  <= var_q;
			gain_out_q <= gain_q;
		end
	end

	assign estimate       = est_out_q;
	assign error_variance = var_out_q;
	assign gain           = gain_out_q;

	a_var_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> var_q <= $past(var_q))
		else $error("update grew the error variance");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prep |=> gain_q <= ONE)
		else $error("gain above one");

	a_predict_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && operation == OP_PREDICT) |=> var_q >= $past(var_q))
		else $error("predict reduced the error variance");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the scalar Kalman filter: directed table, then random phases.
module testbench;
	import skf_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam longint GAIN_ONE = longint'(1) << FRAC_BITS;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 2 * FRAC_BITS + 16;
	localparam int RANDOM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 240;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam bit ROW_ITEM = 1'b0;
	localparam bit ROW_WRITE = 1'b1;
	localparam bit FROM_MODEL = 1'b0;
	localparam bit TYPED = 1'b1;

	typedef struct packed {
		logic signed [31:0] est;
		logic [31:0] variance;
		logic [FRAC_BITS:0] gain;
	} filter_out_t;

	typedef struct packed {
		bit kind;
		cfg_idx_t reg_idx;
		logic [31:0] wdata;
		logic [1:0] op;
		logic [31:0] meas;
		bit typed;
		logic [31:0] est;
		logic [31:0] variance;
		logic [FRAC_BITS:0] gain;
	} stim_row_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_CHOPPY,
		RX_SLOW
	} rx_mode_t;

	localparam stim_row_t DIRECTED_ROWS [32] = '{
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_PREDICT, 32'h0, TYPED, 32'h0, 32'd66191, 17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_UPDATE, 32'h0001_0000, FROM_MODEL, 32'h0, 32'h0, 17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_UPDATE, 32'h7FFF_FFFF, FROM_MODEL, 32'h0, 32'h0, 17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_UPDATE, 32'h8000_0000, FROM_MODEL, 32'h0, 32'h0, 17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_PREDICT, 32'h0, FROM_MODEL, 32'h0, 32'h0, 17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_UNUSED, 32'hFFFF_FFFF, FROM_MODEL, 32'h0, 32'h0,
			17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_RESTART, 32'h0, TYPED, 32'h0, 32'd65536, 17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_UNUSED, 32'h0, TYPED, 32'h0, 32'd65536, 17'd0},
		// variance saturation
		'{ROW_WRITE, CFG_PROC_NOISE, 32'hFFFF_FFFF, OP_PREDICT, 32'h0, FROM_MODEL, 32'h0, 32'h0,
			17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_PREDICT, 32'h0, TYPED, 32'h0, 32'hFFFF_FFFF, 17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_UPDATE, 32'h7FFF_FFFF, FROM_MODEL, 32'h0, 32'h0, 17'd0},
		// zero denominator, then gain of exactly one
		'{ROW_WRITE, CFG_MEAS_NOISE, 32'h0, OP_PREDICT, 32'h0, FROM_MODEL, 32'h0, 32'h0, 17'd0},
		'{ROW_WRITE, CFG_START_ERR, 32'h0, OP_PREDICT, 32'h0, FROM_MODEL, 32'h0, 32'h0, 17'd0},
		'{ROW_WRITE, CFG_START_EST, 32'h8000_0000, OP_PREDICT, 32'h0, FROM_MODEL, 32'h0, 32'h0,
			17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_RESTART, 32'h0, TYPED, 32'h8000_0000, 32'h0, 17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_UPDATE, 32'h7FFF_FFFF, TYPED, 32'h8000_0000, 32'h0,
			17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_PREDICT, 32'h0, TYPED, 32'h8000_0000, 32'hFFFF_FFFF,
			17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_UPDATE, 32'h7FFF_FFFF, TYPED, 32'h7FFF_FFFF, 32'h0,
			17'd65536},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_UPDATE, 32'h8000_0000, TYPED, 32'h7FFF_FFFF, 32'h0,
			17'd0},
		// opposite extremes
		'{ROW_WRITE, CFG_PROC_NOISE, 32'h0, OP_PREDICT, 32'h0, FROM_MODEL, 32'h0, 32'h0, 17'd0},
		'{ROW_WRITE, CFG_MEAS_NOISE, 32'hFFFF_FFFF, OP_PREDICT, 32'h0, FROM_MODEL, 32'h0, 32'h0,
			17'd0},
		'{ROW_WRITE, CFG_START_ERR, 32'hFFFF_FFFF, OP_PREDICT, 32'h0, FROM_MODEL, 32'h0, 32'h0,
			17'd0},
		'{ROW_WRITE, CFG_START_EST, 32'h7FFF_FFFF, OP_PREDICT, 32'h0, FROM_MODEL, 32'h0, 32'h0,
			17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_RESTART, 32'h0, TYPED, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_UPDATE, 32'h8000_0000, FROM_MODEL, 32'h0, 32'h0, 17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_PREDICT, 32'h0, FROM_MODEL, 32'h0, 32'h0, 17'd0},
		'{ROW_WRITE, CFG_PROC_NOISE, PROC_NOISE_RESET, OP_PREDICT, 32'h0, FROM_MODEL, 32'h0, 32'h0,
			17'd0},
		'{ROW_WRITE, CFG_MEAS_NOISE, MEAS_NOISE_RESET, OP_PREDICT, 32'h0, FROM_MODEL, 32'h0, 32'h0,
			17'd0},
		'{ROW_WRITE, CFG_START_EST, START_EST_RESET, OP_PREDICT, 32'h0, FROM_MODEL, 32'h0, 32'h0,
			17'd0},
		'{ROW_WRITE, CFG_START_ERR, START_ERR_RESET, OP_PREDICT, 32'h0, FROM_MODEL, 32'h0, 32'h0,
			17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_RESTART, 32'h0, TYPED, 32'h0, 32'd65536, 17'd0},
		'{ROW_ITEM, CFG_PROC_NOISE, 32'h0, OP_UPDATE, 32'hFFFF_0000, FROM_MODEL, 32'h0, 32'h0, 17'd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_PROC_NOISE;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] operation = OP_PREDICT;
	logic signed [31:0] measurement = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] estimate;
	logic [31:0] error_variance;
	logic [FRAC_BITS:0] gain;

	// filter state and register copies tracked by the predictor
	logic signed [31:0] model_est;
	logic [31:0] model_var;
	logic [FRAC_BITS:0] model_gain;
	logic [31:0] noise_q;
	logic [31:0] noise_r;
	logic signed [31:0] restart_est;
	logic [31:0] restart_var;

	filter_out_t pending_outputs[$];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int burst_left = 0;
	rx_mode_t rx_mode = RX_FREE;
	int rx_left = 0;

	scalar_kalman_filter #(.FRAC_BITS(FRAC_BITS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.measurement(measurement),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.estimate(estimate),
		.error_variance(error_variance),
		.gain(gain)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void reset_filter_model();
		noise_q = PROC_NOISE_RESET;
		noise_r = MEAS_NOISE_RESET;
		restart_est = START_EST_RESET;
		restart_var = START_ERR_RESET;
		model_est = START_EST_RESET;
		model_var = START_ERR_RESET;
		model_gain = '0;
	endfunction

	function automatic filter_out_t kalman_step(logic [1:0] op, logic signed [31:0] meas);
		longint sum;
		longint den;
		longint k;
		longint x;
		longint m;
		longint prod;
		longint nx;
		longint shrunk;
		filter_out_t r;
		case (op)
			OP_PREDICT: begin
				sum = longint'({32'd0, model_var}) + longint'({32'd0, noise_q});
				model_var = (sum > longint'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : sum[31:0];
			end
			OP_UPDATE: begin
				den = longint'({32'd0, model_var}) + longint'({32'd0, noise_r});
				k = 0;
				if (den != 0)
					k = (longint'({32'd0, model_var}) << FRAC_BITS) / den;
				if (k > GAIN_ONE)
					k = GAIN_ONE;
				model_gain = k[FRAC_BITS:0];
				x = longint'(model_est);
				m = longint'(meas);
				prod = k * (m - x);
				// arithmetic shift floors toward minus infinity
				nx = x + (prod >>> FRAC_BITS);
				if (nx > longint'(32'sh7FFF_FFFF))
					nx = longint'(32'sh7FFF_FFFF);
				if (nx < -longint'(64'h8000_0000))
					nx = -longint'(64'h8000_0000);
				model_est = nx[31:0];
				shrunk = ((GAIN_ONE - k) * longint'({32'd0, model_var})) >> FRAC_BITS;
				model_var = shrunk[31:0];
			end
			OP_RESTART: begin
				model_est = restart_est;
				model_var = restart_var;
				model_gain = '0;
			end
			default: begin
			end
		endcase
		r.est = model_est;
		r.variance = model_var;
		r.gain = model_gain;
		return r;
	endfunction

	// bursts of back-to-back items separated by random gaps
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_item(logic [1:0] op, logic [31:0] meas, bit typed,
			filter_out_t typed_out);
		filter_out_t predicted;
		pace_sender();
		cfg_valid <= 1'b0;
		in_valid <= 1'b1;
		operation <= op;
		measurement <= meas;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		predicted = kalman_step(op, meas);
		pending_outputs.push_back(typed ? typed_out : predicted);
	endtask

	task automatic wait_until_idle();
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
	endtask

	// leaves cfg_valid high; the next item transfer drops it
	task automatic write_register(cfg_idx_t idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		case (idx)
			CFG_PROC_NOISE: noise_q = data;
			CFG_MEAS_NOISE: noise_r = data;
			CFG_START_EST: restart_est = data;
			CFG_START_ERR: restart_var = data;
		endcase
	endtask

	function automatic logic [31:0] pick_variance();
		case ($urandom_range(0, 4))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 32'h0010_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_start_estimate();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [1:0] pick_operation();
		int r;
		r = $urandom_range(0, 19);
		if (r < 7)
			return OP_PREDICT;
		if (r < 16)
			return OP_UPDATE;
		if (r < 18)
			return OP_RESTART;
		return OP_UNUSED;
	endfunction

	// mostly readings near the current estimate, some anywhere, some at the rails
	function automatic logic [31:0] pick_measurement();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom;
			default: return model_est + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	// receiver stall pattern: free-running, choppy or mostly stalled stretches
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_left <= $urandom_range(20, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_FREE: out_ready <= 1'b1;
			RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		filter_out_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_outputs.size() == 0) begin
				$error("result transfer with no expected result pending");
				mismatches++;
			end else begin
				want = pending_outputs.pop_front();
				if (estimate !== want.est) begin
					$error("estimate: expected %0d, got %0d", want.est, estimate);
					mismatches++;
				end
				if (error_variance !== want.variance) begin
					$error("error_variance: expected %0d, got %0d", want.variance,
						error_variance);
					mismatches++;
				end
				if (gain !== want.gain) begin
					$error("gain: expected %0d, got %0d", want.gain, gain);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		filter_out_t typed_out;
		reset_filter_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
				wait_until_idle();
				write_register(DIRECTED_ROWS[i].reg_idx, DIRECTED_ROWS[i].wdata);
			end else begin
				typed_out.est = DIRECTED_ROWS[i].est;
				typed_out.variance = DIRECTED_ROWS[i].variance;
				typed_out.gain = DIRECTED_ROWS[i].gain;
				send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].meas, DIRECTED_ROWS[i].typed,
					typed_out);
			end
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_until_idle();
			write_register(CFG_PROC_NOISE, pick_variance());
			write_register(CFG_MEAS_NOISE, pick_variance());
			write_register(CFG_START_EST, pick_start_estimate());
			write_register(CFG_START_ERR, pick_variance());
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_item(pick_operation(), pick_measurement(), FROM_MODEL, '0);
		end

		wait_until_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_outputs.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
